>>> rtl/assert_macros.svh
// Assertion macros shared by the bit writer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);
// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (cond)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, ck, rn, cond, msg)
`endif

`endif

>>> rtl/mbw_pkg.sv
// Shared types and constants for the MSB-first bit writer.
// No dependencies; used by the front end, back end and top level of the block.
`default_nettype none

package mbw_pkg;

  // Width of the capacity register and of the reported bit total
  localparam int CAP_W = 24;
  localparam int BW_W  = 24;

  // Request kinds on the input channel
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_NONSYM = 2'd1;
  localparam logic [1:0] KIND_PAD    = 2'd2;

  // Configuration register indexes
  localparam logic CFG_CAPACITY   = 1'b0;
  localparam logic CFG_COUNT_ONLY = 1'b1;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_PAD
  } op_t;

  // Back end sequencer states
  typedef enum logic {
    BS_IDLE,
    BS_EMIT
  } bstate_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             count_only;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [7:0]      out_byte;
    logic            byte_valid;
    logic            last;
    logic            status;
    logic [BW_W-1:0] bits_written;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/mbw_front.sv
// Front end: accepts requests, works out field length and value.
// Depends on mbw_pkg.
`default_nettype none

module mbw_front #(
  parameter int MAX_FIELD_BITS = 64,
  localparam int NW = $clog2(MAX_FIELD_BITS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output      logic                      in_full,
  input  wire logic [1:0]                in_kind,
  input  wire logic [63:0]               in_value,
  input  wire logic [6:0]                in_bit_count,
  input  wire logic [31:0]               in_symbol_range,
  input  wire logic                      q_full,
  output      logic                      q_push,
  output      mbw_pkg::op_t              q_op,
  output      logic [MAX_FIELD_BITS-1:0] q_v,
  output      logic [NW-1:0]             q_n
);

  logic        f_valid_r, f_valid_nxt;
  logic [1:0]  f_kind_r;
  logic [63:0] f_value_r;
  logic [6:0]  f_count_r;
  logic [5:0]  f_w_r;
  logic [31:0] f_m_r;
  logic        f_small_r;

  logic [5:0]  w_in;
  logic [32:0] m_wide;
  logic        accept;
  logic        lt;
  logic [6:0]  n_raw;
  logic [6:0]  n_sat;
  logic [63:0] v_sel;
  logic [63:0] v_mask;

  // Bit length of the symbol range
  always_comb begin
    w_in = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_symbol_range[i]) w_in = 6'(i + 1);
    end
  end

  // m = 2^w - range, at most 2^31
  assign m_wide = (33'd1 << w_in) - {1'b0, in_symbol_range};

  assign in_full = f_valid_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = f_valid_r & ~q_full;

  // Input register
  always_comb begin
    f_valid_nxt = f_valid_r;
    if (!f_valid_r || !q_full) f_valid_nxt = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_kind_r  <= in_kind;
      f_value_r <= in_value;
      f_count_r <= in_bit_count;
      f_w_r     <= w_in;
      f_m_r     <= m_wide[31:0];
      f_small_r <= (in_symbol_range <= 32'd1);
    end
  end

  // Classify and pick length and value
  assign lt = f_value_r < {32'd0, f_m_r};

  always_comb begin
    q_op  = mbw_pkg::OP_NOP;
    n_raw = '0;
    v_sel = f_value_r;
    case (f_kind_r)
      mbw_pkg::KIND_PLAIN: begin
        q_op  = mbw_pkg::OP_WRITE;
        n_raw = f_count_r;
      end
      mbw_pkg::KIND_NONSYM: begin
        if (!f_small_r) begin
          q_op = mbw_pkg::OP_WRITE;
          if (lt) begin
            n_raw = 7'(f_w_r - 6'd1);
          end else begin
            n_raw = 7'(f_w_r);
            v_sel = f_value_r + {32'd0, f_m_r};
          end
        end
      end
      mbw_pkg::KIND_PAD: begin
        q_op = mbw_pkg::OP_PAD;
      end
      default: begin
        q_op = mbw_pkg::OP_NOP;
      end
    endcase
  end

  // Clamp length to the widest field and keep only its bits
  assign n_sat  = (n_raw > 7'(MAX_FIELD_BITS)) ? 7'(MAX_FIELD_BITS) : n_raw;
  assign v_mask = v_sel & ~({64{1'b1}} << n_sat);
  assign q_v    = v_mask[MAX_FIELD_BITS-1:0];
  assign q_n    = NW'(n_sat);

endmodule

`default_nettype wire

>>> rtl/mbw_queue.sv
// Two-entry request queue between front and back end.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbw_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] wdata,
  output      logic          full,
  input  wire logic          pop,
  output      logic          valid,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign rdata   = mem_r[rd_r];

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= wdata;
  end

  `ASSERT_ALWAYS(a_q_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH), "queue overfilled")

endmodule

`default_nettype wire

>>> rtl/mbw_back.sv
// Back end: capacity check, byte packing and result register.
// Depends on mbw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbw_back #(
  parameter int MAX_FIELD_BITS = 64,
  parameter int OFFSET_BITS    = 24,
  localparam int NW  = $clog2(MAX_FIELD_BITS + 1),
  localparam int SW  = MAX_FIELD_BITS + 8,
  localparam int TW  = $clog2(MAX_FIELD_BITS + 8),
  localparam int BCW = $clog2(SW / 8 + 1),
  localparam int LW  = ((OFFSET_BITS > mbw_pkg::CAP_W) ? OFFSET_BITS : mbw_pkg::CAP_W) + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mbw_pkg::cfg_t             cfg,
  input  wire logic                      q_valid,
  input  wire mbw_pkg::op_t              q_op,
  input  wire logic [MAX_FIELD_BITS-1:0] q_v,
  input  wire logic [NW-1:0]             q_n,
  output      logic                      q_pop,
  output      logic                      out_valid,
  output      mbw_pkg::res_t             out_res,
  input  wire logic                      out_pop
);

  localparam logic [LW-1:0] OMAX = {{(LW - OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};

  mbw_pkg::bstate_t state_r, state_nxt;
  logic [6:0]             pb_r, pb_nxt;
  logic [2:0]             pc_r, pc_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [SW-1:0]          shift_r, shift_nxt;
  logic [BCW-1:0]         cnt_r, cnt_nxt;
  logic [mbw_pkg::BW_W-1:0] bw_r, bw_nxt;
  logic                   ov_r, ov_nxt;
  mbw_pkg::res_t          res_r, res_nxt;

  logic                   slot_free;
  logic [LW-1:0]          cap_ext, lim;
  logic [LW-1:0]          wr_sum;
  logic                   wr_over;
  logic [TW-1:0]          tot;
  logic [BCW-1:0]         nbytes;
  logic [2:0]             rem;
  logic [7:0]             p8;
  logic [MAX_FIELD_BITS-1:0] vl;
  logic [SW-1:0]          stream;
  logic [6:0]             pb_sh, pb_new, rem_mask;
  logic [2:0]             pad;
  logic [LW-1:0]          pad_tot;
  logic                   pad_ok;
  logic [7:0]             pad_byte;

  assign slot_free = ~ov_r | out_pop;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  // Bit budget: the smaller of capacity and the offset range
  assign cap_ext = LW'(cfg.capacity);
  assign lim     = (cap_ext < OMAX) ? cap_ext : OMAX;
  assign wr_sum  = LW'(off_r) + LW'(q_n);
  assign wr_over = wr_sum > lim;

  // Partial byte plus new field, left aligned
  assign tot    = TW'(pc_r) + TW'(q_n);
  assign nbytes = BCW'(tot >> 3);
  assign rem    = tot[2:0];
  assign p8     = 8'({1'b0, pb_r} << (4'd8 - 4'(pc_r)));
  assign vl     = q_v << (NW'(MAX_FIELD_BITS) - q_n);
  assign stream = {p8, {MAX_FIELD_BITS{1'b0}}} | ({vl, 8'd0} >> pc_r);

  // Bits left over after the last full byte
  assign pb_sh    = pb_r << q_n[2:0];
  assign rem_mask = 7'((8'd1 << rem) - 8'd1);
  assign pb_new   = ((q_n >= NW'(7)) ? q_v[6:0] : (pb_sh | q_v[6:0])) & rem_mask;

  // Pad to the byte boundary
  assign pad      = 3'd0 - pc_r;
  assign pad_tot  = LW'(off_r) + LW'(pad);
  assign pad_ok   = pad_tot <= lim;
  assign pad_byte = 8'({1'b0, pb_r} << pad);

  // Sequencer: one result per cycle into the output register while it is free or being popped
  always_comb begin
    state_nxt = state_r;
    pb_nxt    = pb_r;
    pc_nxt    = pc_r;
    off_nxt   = off_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    bw_nxt    = bw_r;
    ov_nxt    = ov_r & ~out_pop;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    case (state_r)
      mbw_pkg::BS_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop   = 1'b1;
          ov_nxt  = 1'b1;
          res_nxt = '0;
          res_nxt.last = 1'b1;
          res_nxt.bits_written = mbw_pkg::BW_W'(off_r);
          case (q_op)
            mbw_pkg::OP_WRITE: begin
              if (wr_over) begin
                res_nxt.status = 1'b1;
              end else begin
                off_nxt = OFFSET_BITS'(wr_sum);
                pb_nxt  = pb_new;
                pc_nxt  = rem;
                res_nxt.bits_written = mbw_pkg::BW_W'(OFFSET_BITS'(wr_sum));
                if (!cfg.count_only && nbytes != '0) begin
                  res_nxt.out_byte   = stream[SW-1 -: 8];
                  res_nxt.byte_valid = 1'b1;
                  res_nxt.last       = (nbytes == BCW'(1));
                  shift_nxt = stream << 8;
                  cnt_nxt   = nbytes - 1'b1;
                  bw_nxt    = mbw_pkg::BW_W'(OFFSET_BITS'(wr_sum));
                  if (nbytes != BCW'(1)) state_nxt = mbw_pkg::BS_EMIT;
                end
              end
            end
            mbw_pkg::OP_PAD: begin
              if (!pad_ok) begin
                res_nxt.status = 1'b1;
              end else begin
                res_nxt.bits_written = mbw_pkg::BW_W'(pad_tot);
                if (pad != 3'd0 && !cfg.count_only) begin
                  res_nxt.out_byte   = pad_byte;
                  res_nxt.byte_valid = 1'b1;
                end
              end
              pb_nxt  = '0;
              pc_nxt  = '0;
              off_nxt = '0;
            end
            default: begin
              res_nxt.status = 1'b0;
            end
          endcase
        end
      end
      mbw_pkg::BS_EMIT: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          res_nxt.out_byte     = shift_r[SW-1 -: 8];
          res_nxt.byte_valid   = 1'b1;
          res_nxt.last         = (cnt_r == BCW'(1));
          res_nxt.status       = 1'b0;
          res_nxt.bits_written = bw_r;
          shift_nxt = shift_r << 8;
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == BCW'(1)) state_nxt = mbw_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = mbw_pkg::BS_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbw_pkg::BS_IDLE;
      pb_r    <= '0;
      pc_r    <= '0;
      off_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pb_r    <= pb_nxt;
      pc_r    <= pc_nxt;
      off_r   <= off_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bw_r    <= bw_nxt;
    res_r   <= res_nxt;
  end

  `ASSERT_IMPLIES(a_emit_cnt, clk, rst_n, state_r == mbw_pkg::BS_EMIT, cnt_r != '0,
    "emit state with no bytes left")
  `ASSERT_IMPLIES(a_reject_last, clk, rst_n, ov_r && res_r.status, res_r.last && !res_r.byte_valid,
    "rejected request must give a single last result")
  `ASSERT_IMPLIES(a_nobyte_last, clk, rst_n, ov_r && !res_r.byte_valid, res_r.last,
    "result without byte must be last")

endmodule

`default_nettype wire

>>> rtl/msb_first_bit_writer_unit.sv
// Top level of the MSB-first bit writer: front end, request queue, back end; uses mbw_pkg.
// A request passes the front end input register, the request queue and the result register.
// Throughput: one request per cycle while results are popped, when it completes at most one
// byte; a request completing k bytes holds the packer until all k are out (one byte per cycle).
// Reset: synchronous active-low rst_n clears queue, counters and partial byte,
// and sets capacity_bits to all ones and count_only to 0. No clearing pass.
`default_nettype none

module msb_first_bit_writer_unit #(
  parameter int MAX_FIELD_BITS = 64,
  parameter int OFFSET_BITS    = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_push,
  output      logic                         in_full,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [63:0]                  in_value,
  input  wire logic [6:0]                   in_bit_count,
  input  wire logic [31:0]                  in_symbol_range,
  // result channel
  output      logic                         out_empty,
  input  wire logic                         out_pop,
  output      logic [7:0]                   out_out_byte,
  output      logic                         out_byte_valid,
  output      logic                         out_last,
  output      logic                         out_status,
  output      logic [mbw_pkg::BW_W-1:0]     out_bits_written,
  // configuration write channel
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [mbw_pkg::CAP_W-1:0]    cfg_data
);

  localparam int NW = $clog2(MAX_FIELD_BITS + 1);
  localparam int QW = 2 + NW + MAX_FIELD_BITS;

  logic [mbw_pkg::CAP_W-1:0] cap_r;
  logic                      cnto_r;
  mbw_pkg::cfg_t             cfg;

  logic                      q_push, q_full, q_pop, q_valid;
  mbw_pkg::op_t              f_op;
  logic [MAX_FIELD_BITS-1:0] f_v;
  logic [NW-1:0]             f_n;
  logic [QW-1:0]             q_wdata, q_rdata;

  logic                      o_valid;
  mbw_pkg::res_t             o_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= {mbw_pkg::CAP_W{1'b1}};
      cnto_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbw_pkg::CFG_CAPACITY:   cap_r  <= cfg_data;
        mbw_pkg::CFG_COUNT_ONLY: cnto_r <= cfg_data[0];
        default:                 cap_r  <= cap_r;
      endcase
    end
  end

  assign cfg.capacity   = cap_r;
  assign cfg.count_only = cnto_r;

  // Front end
  mbw_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .in_bit_count   (in_bit_count),
    .in_symbol_range(in_symbol_range),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (f_op),
    .q_v            (f_v),
    .q_n            (f_n)
  );

  // Request queue
  assign q_wdata = {f_op, f_n, f_v};

  mbw_queue #(
    .DW   (QW),
    .DEPTH(2)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  // Back end
  mbw_back #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_op     (mbw_pkg::op_t'(q_rdata[QW-1 -: 2])),
    .q_v      (q_rdata[MAX_FIELD_BITS-1:0]),
    .q_n      (q_rdata[MAX_FIELD_BITS +: NW]),
    .q_pop    (q_pop),
    .out_valid(o_valid),
    .out_res  (o_res),
    .out_pop  (out_pop)
  );

  assign out_empty        = ~o_valid;
  assign out_out_byte     = o_res.out_byte;
  assign out_byte_valid   = o_res.byte_valid;
  assign out_last         = o_res.last;
  assign out_status       = o_res.status;
  assign out_bits_written = o_res.bits_written;

endmodule

`default_nettype wire

>>> tb/sv/msb_first_bit_writer_checker.sv
`timescale 1ns / 1ps
// Result checker for the MSB-first bit writer: watches request, result and register channels,
// packs every accepted request itself and compares each popped result with the oldest one due.
// Depends on mbw_pkg for the result struct, request kinds and register indexes.
module msb_first_bit_writer_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  input  wire logic                       in_full,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [63:0]                in_value,
  input  wire logic [6:0]                 in_bit_count,
  input  wire logic [31:0]                in_symbol_range,
  input  wire logic                       out_empty,
  input  wire logic                       out_pop,
  input  wire logic [7:0]                 out_out_byte,
  input  wire logic                       out_byte_valid,
  input  wire logic                       out_last,
  input  wire logic                       out_status,
  input  wire logic [mbw_pkg::BW_W-1:0]   out_bits_written,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [mbw_pkg::CAP_W-1:0]  cfg_data,
  output int                              error_count,
  output int                              outstanding
);

  localparam int FIELD_MAX = 64;

  // results still owed by the block, oldest first
  mbw_pkg::res_t             byte_queue[$];
  // shadow of the packer state and registers
  logic [mbw_pkg::CAP_W-1:0] cap_reg;
  logic                      count_only_reg;
  logic [6:0]                partial_bits;
  int                        partial_len;
  logic [mbw_pkg::BW_W-1:0]  msg_bits;
  int                        fails = 0;
  int                        held = 0;

  assign error_count = fails;
  assign outstanding = held;

  function automatic mbw_pkg::res_t make_result(logic [7:0] b, logic v, logic l, logic s,
                                                logic [mbw_pkg::BW_W-1:0] t);
    mbw_pkg::res_t r;
    r.out_byte     = b;
    r.byte_valid   = v;
    r.last         = l;
    r.status       = s;
    r.bits_written = t;
    return r;
  endfunction

  // Append the low n bits of v, MSB first; one result per emitted byte, else one byte-less result
  function automatic void append_bits(logic [63:0] v, int n);
    mbw_pkg::res_t          made[8];
    int                     cnt;
    int                     fill;
    logic [7:0]             acc;
    logic [mbw_pkg::BW_W:0] sum;
    cnt = 0;
    if (n > FIELD_MAX) n = FIELD_MAX;
    sum = {1'b0, msg_bits} + (mbw_pkg::BW_W + 1)'(n);
    // whole write rejected when it would pass the capacity
    if (sum > cap_reg) begin
      byte_queue.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1, msg_bits));
      return;
    end
    msg_bits = sum[mbw_pkg::BW_W-1:0];
    acc = {1'b0, partial_bits};
    fill = partial_len;
    for (int i = n - 1; i >= 0; i--) begin
      acc = {acc[6:0], v[i]};
      fill++;
      if (fill == 8) begin
        if (!count_only_reg && cnt < 8) begin
          made[cnt] = make_result(acc, 1'b1, 1'b0, 1'b0, msg_bits);
          cnt++;
        end
        acc = 8'h00;
        fill = 0;
      end
    end
    partial_bits = acc[6:0];
    partial_len = fill;
    if (cnt == 0) begin
      byte_queue.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0, msg_bits));
    end else begin
      made[cnt-1].last = 1'b1;
      for (int j = 0; j < cnt; j++) byte_queue.push_back(made[j]);
    end
  endfunction

  // Truncated binary code of v for an alphabet of range symbols
  function automatic void code_symbol(logic [63:0] v, logic [31:0] range);
    logic [63:0] m;
    int          w;
    // ranges of zero or one carry no information
    if (range <= 1) begin
      byte_queue.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0, msg_bits));
      return;
    end
    w = 0;
    for (int b = 0; b < 32; b++) if (range[b]) w = b + 1;
    m = (64'd1 << w) - {32'd0, range};
    if (v < m) append_bits(v, w - 1);
    else append_bits(v + m, w);
  endfunction

  // Zero fill to the byte boundary and start a new message
  function automatic void close_message();
    int                     pad;
    logic [mbw_pkg::BW_W:0] total;
    logic [7:0]             tail;
    pad = (8 - partial_len) % 8;
    total = {1'b0, msg_bits} + (mbw_pkg::BW_W + 1)'(pad);
    tail = {1'b0, partial_bits} << pad;
    if (total > cap_reg)
      byte_queue.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1, msg_bits));
    else if (pad != 0 && !count_only_reg)
      byte_queue.push_back(make_result(tail, 1'b1, 1'b1, 1'b0,
                                       total[mbw_pkg::BW_W-1:0]));
    else
      byte_queue.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0,
                                       total[mbw_pkg::BW_W-1:0]));
    partial_bits = '0;
    partial_len = 0;
    msg_bits = '0;
  endfunction

  // Sample all channels at the edge; results first, then registers, then requests
  always @(posedge clk) begin : watch
    mbw_pkg::res_t want;
    mbw_pkg::res_t seen;
    seen = make_result(out_out_byte, out_byte_valid, out_last, out_status, out_bits_written);
    if (!rst_n) begin
      byte_queue.delete();
      cap_reg = '1;
      count_only_reg = 1'b0;
      partial_bits = '0;
      partial_len = 0;
      msg_bits = '0;
    end else begin
      if (out_pop && !out_empty) begin
        if (byte_queue.size() == 0) begin
          $display({"%0t: mismatch expected no result",
                    " / actual byte=%h valid=%b last=%b status=%b bits=%0d"},
                   $time, seen.out_byte, seen.byte_valid, seen.last, seen.status,
                   seen.bits_written);
          fails++;
        end else begin
          want = byte_queue.pop_front();
          if (seen.out_byte !== want.out_byte || seen.byte_valid !== want.byte_valid ||
              seen.last !== want.last || seen.status !== want.status ||
              seen.bits_written !== want.bits_written) begin
            $display({"%0t: mismatch expected byte=%h valid=%b last=%b status=%b bits=%0d",
                      " / actual byte=%h valid=%b last=%b status=%b bits=%0d"},
                     $time, want.out_byte, want.byte_valid, want.last, want.status,
                     want.bits_written, seen.out_byte, seen.byte_valid, seen.last,
                     seen.status, seen.bits_written);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mbw_pkg::CFG_CAPACITY) cap_reg = cfg_data;
        else count_only_reg = cfg_data[0];
      end
      if (in_push && !in_full) begin
        case (in_kind)
          mbw_pkg::KIND_PLAIN:  append_bits(in_value, int'(in_bit_count));
          mbw_pkg::KIND_NONSYM: code_symbol(in_value, in_symbol_range);
          mbw_pkg::KIND_PAD:    close_message();
          default: byte_queue.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0, msg_bits));
        endcase
      end
    end
    held = byte_queue.size();
  end

endmodule

>>> tb/sv/msb_first_bit_writer_unit_tb.sv
`timescale 1ns / 1ps
// Top of the MSB-first bit writer testbench: clock, reset, request and register stimulus,
// random result draining and the verdict. Needs mbw_pkg, the unit and the checker module.
module msb_first_bit_writer_unit_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 6;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [1:0]                 in_kind = '0;
  logic [63:0]                in_value = '0;
  logic [6:0]                 in_bit_count = '0;
  logic [31:0]                in_symbol_range = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic [7:0]                 out_out_byte;
  logic                       out_byte_valid;
  logic                       out_last;
  logic                       out_status;
  logic [mbw_pkg::BW_W-1:0]   out_bits_written;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = 1'b0;
  logic [mbw_pkg::CAP_W-1:0]  cfg_data = '0;

  int error_count;
  int outstanding;
  int cycle_count = 0;
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  msb_first_bit_writer_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .in_bit_count     (in_bit_count),
    .in_symbol_range  (in_symbol_range),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_out_byte     (out_out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_bits_written (out_bits_written),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  msb_first_bit_writer_checker bit_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .in_bit_count     (in_bit_count),
    .in_symbol_range  (in_symbol_range),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_out_byte     (out_out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_bits_written (out_bits_written),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .error_count      (error_count),
    .outstanding      (outstanding)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one request after a random gap, or none when eager; returns at the edge that takes it
  task automatic send_request(input logic [1:0] kind, input logic [63:0] value,
                              input logic [6:0] count, input logic [31:0] range);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_kind <= kind;
    in_value <= value;
    in_bit_count <= count;
    in_symbol_range <= range;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has been popped
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [mbw_pkg::CAP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly short fields and in-range symbols, with pads to keep messages bounded
  task automatic send_random_request();
    int          pick;
    int          sel;
    logic [1:0]  kind;
    logic [63:0] value;
    logic [6:0]  count;
    logic [31:0] range;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    value = {$urandom, $urandom};
    count = 7'($urandom_range(0, 127));
    range = $urandom;
    if (pick < 45) begin
      kind = mbw_pkg::KIND_PLAIN;
      if (sel < 7) count = 7'($urandom_range(0, 16));
      else if (sel < 9) count = 7'($urandom_range(17, 64));
      else count = 7'($urandom_range(65, 127));
      if ($urandom_range(0, 3) == 0) value = value & ((64'd1 << $urandom_range(0, 63)) - 1);
    end else if (pick < 83) begin
      kind = mbw_pkg::KIND_NONSYM;
      if (sel < 6) range = $urandom_range(2, 300);
      else if (sel == 9) range = $urandom_range(0, 1);
      if (range > 1 && $urandom_range(0, 4) != 0) value = 64'($urandom_range(0, range - 1));
    end else if (pick < 97) begin
      kind = mbw_pkg::KIND_PAD;
    end else begin
      kind = KIND_UNUSED;
    end
    send_request(kind, value, count, range);
  endtask

  // Result side: random stalls, eager stretches and one long hold-off
  initial begin : drain
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
        stall = rx_eager ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  // Request side and verdict
  initial begin : stimulus
    logic [mbw_pkg::CAP_W-1:0] cap;
    logic                      only;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, every kind, coding corner cases
    send_request(mbw_pkg::KIND_PLAIN, 64'h0, 7'd0, 32'd1);
    send_request(mbw_pkg::KIND_PLAIN, '1, 7'd64, 32'hFFFF_FFFF);
    send_request(mbw_pkg::KIND_PLAIN, 64'h0123_4567_89AB_CDEF, 7'd127, 32'd0);
    send_request(mbw_pkg::KIND_PLAIN, 64'h5, 7'd3, 32'd0);
    send_request(mbw_pkg::KIND_PAD, 64'h0, 7'd0, 32'd0);
    send_request(mbw_pkg::KIND_PAD, 64'h0, 7'd0, 32'd0);
    send_request(mbw_pkg::KIND_NONSYM, 64'd7, 7'd0, 32'd0);
    send_request(mbw_pkg::KIND_NONSYM, 64'd7, 7'd0, 32'd1);
    send_request(mbw_pkg::KIND_NONSYM, 64'd0, 7'd0, 32'd5);
    send_request(mbw_pkg::KIND_NONSYM, 64'd4, 7'd0, 32'd5);
    send_request(mbw_pkg::KIND_NONSYM, '1, 7'd0, 32'd5);
    send_request(mbw_pkg::KIND_NONSYM, 64'hFFFF_FFFE, 7'd0, 32'hFFFF_FFFF);
    send_request(mbw_pkg::KIND_NONSYM, 64'h1234, 7'd0, 32'h8000_0000);
    send_request(KIND_UNUSED, '1, 7'h7F, 32'hFFFF_FFFF);
    send_request(mbw_pkg::KIND_PAD, 64'h0, 7'd0, 32'd0);

    // tight capacity: exact fit, rejected write, rejected pad
    settle();
    write_reg(mbw_pkg::CFG_CAPACITY, 24'd20);
    send_request(mbw_pkg::KIND_PLAIN, 64'hBEEF, 7'd16, 32'd0);
    send_request(mbw_pkg::KIND_PLAIN, 64'hFF, 7'd8, 32'd0);
    send_request(mbw_pkg::KIND_PLAIN, 64'h5, 7'd3, 32'd0);
    send_request(mbw_pkg::KIND_PAD, 64'h0, 7'd0, 32'd0);
    send_request(mbw_pkg::KIND_PLAIN, 64'hA_BCDE, 7'd20, 32'd0);
    send_request(mbw_pkg::KIND_PAD, 64'h0, 7'd0, 32'd0);

    // count only at full capacity
    settle();
    write_reg(mbw_pkg::CFG_CAPACITY, '1);
    write_reg(mbw_pkg::CFG_COUNT_ONLY, 24'd1);
    send_request(mbw_pkg::KIND_PLAIN, '1, 7'd64, 32'd0);
    send_request(mbw_pkg::KIND_PLAIN, 64'h15, 7'd5, 32'd0);
    send_request(mbw_pkg::KIND_PAD, 64'h0, 7'd0, 32'd0);

    // zero capacity: only empty writes get through
    settle();
    write_reg(mbw_pkg::CFG_COUNT_ONLY, 24'd0);
    write_reg(mbw_pkg::CFG_CAPACITY, 24'd0);
    send_request(mbw_pkg::KIND_PLAIN, 64'h1, 7'd1, 32'd0);
    send_request(mbw_pkg::KIND_NONSYM, 64'h0, 7'd0, 32'd2);
    send_request(mbw_pkg::KIND_PAD, 64'h0, 7'd0, 32'd0);

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      cap = '1;
      only = 1'b0;
      case (ph)
        1: cap = 24'($urandom_range(40, 400));
        2: only = 1'b1;
        3: begin
          cap = 24'($urandom);
          only = 1'($urandom_range(0, 1));
        end
        default: ;
      endcase
      write_reg(mbw_pkg::CFG_CAPACITY, cap);
      write_reg(mbw_pkg::CFG_COUNT_ONLY, {{(mbw_pkg::CAP_W-1){1'b0}}, only});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 15) == 0) tx_eager = !tx_eager;
        if (ph == 0 && i == 30) hold_request = 1'b1;
        send_random_request();
      end
    end
    settle();

    if (error_count == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/mbw_pkg.sv
rtl/mbw_front.sv
rtl/mbw_queue.sv
rtl/mbw_back.sv
rtl/msb_first_bit_writer_unit.sv
tb/sv/msb_first_bit_writer_checker.sv
tb/sv/msb_first_bit_writer_unit_tb.sv
